// ----- sv/pvc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pvc_pkg: shared types and constants of the progressive Vigenere cipher unit
// Holds the character codes, register indexes, field widths and small
// mod-26 helpers used by the top level.
// -----------------------------------------------------------------------------
package pvc_pkg;

	localparam int KEY_MAX_DEF = 16;
	localparam int KEY_BYTES   = 16;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int LEN_W       = 5;
	localparam int POS_W       = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_OFFSET = 2'd3;

	localparam logic [7:0] CHAR_LO    = 8'd97;
	localparam logic [7:0] CHAR_HI    = 8'd122;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [4:0] ALPHA_LEN  = 5'd26;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] char_out;
		logic       error;
	} res_t;

	// Remainder of a byte by 26. The quotient comes from a multiply by 79/2048,
	// which is exact over the whole byte range.
	function automatic logic [4:0] byte_mod26(input logic [7:0] b);
		logic [14:0] prod;
		logic [3:0]  quo;
		logic [7:0]  rem;
		prod = 15'(b) * 15'd79;
		quo  = prod[14:11];
		rem  = b - 8'(quo) * 8'(ALPHA_LEN);
		return rem[4:0];
	endfunction

	// Reduce a value below 32 to its remainder by 26.
	function automatic logic [4:0] small_mod26(input logic [4:0] v);
		return (v >= ALPHA_LEN) ? v - ALPHA_LEN : v;
	endfunction

endpackage

// ----- sv/pvc_in_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pvc_in_if: input character channel
// Valid/ready channel carrying one character with its request type and
// first-of-message mark.
// -----------------------------------------------------------------------------
interface pvc_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic       first;
	logic [7:0] char_in;

	modport source (output valid, output req_type, output first, output char_in,
		input ready);
	modport sink (input valid, input req_type, input first, input char_in,
		output ready);
endinterface

// ----- sv/pvc_out_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pvc_out_if: result character channel
// Valid/ready channel carrying one transformed character and its error flag.
// -----------------------------------------------------------------------------
interface pvc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       error;

	modport source (output valid, output char_out, output error, input ready);
	modport sink (input valid, input char_out, input error, output ready);
endinterface

// ----- sv/progressive_vigenere_cipher_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// progressive_vigenere_cipher_unit: progressive Vigenere cipher, one char per cycle unless the output stalls
// Results are registered in a two-entry buffer and leave in order of arrival.
// Throughput: one character per cycle while the output side accepts; the buffer
// lets input accept one more character while the output side stalls.
// Reset: key registers 0, key length 1, shift offset 0, key index, position and
// sticky error cleared, result buffer emptied.
// -----------------------------------------------------------------------------
module progressive_vigenere_cipher_unit #(
	parameter int KEY_MAX = pvc_pkg::KEY_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pvc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pvc_pkg::CFG_W-1:0]     cfg_wdata,
	pvc_in_if.sink                        in_ch,
	pvc_out_if.source                     out_ch
);

	localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [pvc_pkg::LEN_W-1:0] KEY_MAX_L = pvc_pkg::LEN_W'(KEY_MAX);

	// Configuration registers
	logic [pvc_pkg::CFG_W-1:0]   key_low_q;
	logic [pvc_pkg::CFG_W-1:0]   key_high_q;
	logic [pvc_pkg::LEN_W-1:0]   key_length_q;
	logic [4:0]                  shift_offset_q;

	// Message state
	logic [KIDX_W-1:0]           key_index_q;
	logic [pvc_pkg::POS_W-1:0]   position_q;
	logic                        aborted_q;

	// Result buffer
	pvc_pkg::res_t               buf0_q;
	pvc_pkg::res_t               buf1_q;
	logic [1:0]                  count_q;

	logic                        in_acc;
	logic                        out_acc;
	logic [pvc_pkg::LEN_W-1:0]   eff_len;
	logic [KIDX_W-1:0]           idx_base;
	logic [KIDX_W-1:0]           idx;
	logic [pvc_pkg::LEN_W-1:0]   idx_inc;
	logic [pvc_pkg::POS_W-1:0]   pos_base;
	logic                        abort_base;
	logic                        bad_char;
	logic                        err;
	logic [3:0]                  key_byte_sel;
	logic [7:0]                  key_byte;
	logic [4:0]                  key_let;
	logic [6:0]                  shift_sum;
	logic [4:0]                  shift;
	logic [4:0]                  letter;
	logic [5:0]                  enc_sum;
	logic [4:0]                  new_letter;
	pvc_pkg::res_t               res;
	logic [127:0]                key_all;

	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_acc      = out_ch.valid && out_ch.ready;
	assign in_ch.ready  = (count_q != 2'd2);
	assign out_ch.valid = (count_q != 2'd0);
	assign out_ch.char_out = buf0_q.char_out;
	assign out_ch.error    = buf0_q.error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q      <= '0;
			key_high_q     <= '0;
			key_length_q   <= pvc_pkg::LEN_W'(1);
			shift_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pvc_pkg::REG_KEY_LOW:      key_low_q      <= cfg_wdata;
				pvc_pkg::REG_KEY_HIGH:     key_high_q     <= cfg_wdata;
				pvc_pkg::REG_KEY_LENGTH:   key_length_q   <= cfg_wdata[pvc_pkg::LEN_W-1:0];
				pvc_pkg::REG_SHIFT_OFFSET: shift_offset_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// Length zero counts as one, anything above the key capacity is clamped.
		if (key_length_q == '0) begin
			eff_len = pvc_pkg::LEN_W'(1);
		end else if (key_length_q > KEY_MAX_L) begin
			eff_len = KEY_MAX_L;
		end else begin
			eff_len = key_length_q;
		end

		idx_base   = in_ch.first ? '0 : key_index_q;
		pos_base   = in_ch.first ? '0 : position_q;
		abort_base = in_ch.first ? 1'b0 : aborted_q;

		// An index left beyond a shortened key falls back to the first letter.
		idx     = (pvc_pkg::LEN_W'(idx_base) >= eff_len) ? '0 : idx_base;
		idx_inc = pvc_pkg::LEN_W'(idx) + pvc_pkg::LEN_W'(1);

		bad_char = (in_ch.char_in != pvc_pkg::CHAR_SPACE)
			&& ((in_ch.char_in < pvc_pkg::CHAR_LO) || (in_ch.char_in > pvc_pkg::CHAR_HI));
		err = abort_base || bad_char;

		key_all      = {key_high_q, key_low_q};
		key_byte_sel = 4'(idx);
		key_byte     = key_all[{key_byte_sel, 3'b000} +: 8];
		key_let      = pvc_pkg::byte_mod26(key_byte);

		shift_sum = 7'(key_let) + 7'(pvc_pkg::small_mod26(shift_offset_q)) + 7'(pos_base);
		if (shift_sum >= 7'd52) begin
			shift = 5'(shift_sum - 7'd52);
		end else if (shift_sum >= 7'd26) begin
			shift = 5'(shift_sum - 7'd26);
		end else begin
			shift = 5'(shift_sum);
		end

		letter  = 5'(in_ch.char_in - pvc_pkg::CHAR_LO);
		enc_sum = 6'(letter) + 6'(shift);
		if (in_ch.req_type == pvc_pkg::REQ_DECODE) begin
			new_letter = (letter >= shift) ? letter - shift
				: letter + pvc_pkg::ALPHA_LEN - shift;
		end else begin
			new_letter = (enc_sum >= 6'(pvc_pkg::ALPHA_LEN))
				? 5'(enc_sum - 6'(pvc_pkg::ALPHA_LEN)) : 5'(enc_sum);
		end

		if (err) begin
			res.char_out = '0;
			res.error    = 1'b1;
		end else if (in_ch.char_in == pvc_pkg::CHAR_SPACE) begin
			res.char_out = pvc_pkg::CHAR_SPACE;
			res.error    = 1'b0;
		end else begin
			res.char_out = 8'(new_letter) + pvc_pkg::CHAR_LO;
			res.error    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_index_q <= '0;
			position_q  <= '0;
			aborted_q   <= 1'b0;
		end else if (in_acc) begin
			if (err) begin
				// A bad message freezes its key index and position.
				key_index_q <= idx_base;
				position_q  <= pos_base;
				aborted_q   <= 1'b1;
			end else begin
				key_index_q <= (idx_inc >= eff_len) ? '0 : KIDX_W'(idx_inc);
				position_q  <= (pos_base == pvc_pkg::ALPHA_LEN - 5'd1) ? '0
					: pos_base + 5'd1;
				aborted_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case (count_q)
				2'd0: if (in_acc) count_q <= 2'd1;
				2'd1: begin
					if (in_acc && !out_acc) begin
						count_q <= 2'd2;
					end else if (!in_acc && out_acc) begin
						count_q <= 2'd0;
					end
				end
				2'd2: if (out_acc) count_q <= 2'd1;
				default: count_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: if (in_acc) buf0_q <= res;
			2'd1: begin
				if (in_acc && out_acc) begin
					buf0_q <= res;
				end else if (in_acc) begin
					buf1_q <= res;
				end
			end
			2'd2: if (out_acc) buf0_q <= buf1_q;
			default: ;
		endcase
	end

endmodule
